// ----- rtl/core/ist_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPID sequence tracker package
// Shared constants, register indexes, sequencer states and the structures
// that travel along the row of sequence cells.
// ----------------------------------------------------------------------------
package ist_pkg;

    localparam int SLOTS_DEFAULT = 16;

    localparam int IPID_W  = 16;
    localparam int STAMP_W = 32;
    localparam int GAP_W   = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_W   = 32;
    localparam int MASK_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int USED_W  = 5;

    localparam logic [GAP_W-1:0]  GAP_LIMIT_RESET  = GAP_W'(64);
    localparam logic [TIME_W-1:0] TIME_LIMIT_RESET = TIME_W'(300);

    // 15-bit modular IPID distance
    localparam logic [IPID_W-1:0] GAP_MOD_MASK = IPID_W'(32767);

    typedef enum logic [0:0] {
        REG_GAP_LIMIT  = 1'b0,
        REG_TIME_LIMIT = 1'b1
    } ist_reg_idx_t;

    typedef enum logic [0:0] {
        ST_IDLE  = 1'b0,
        ST_SWEEP = 1'b1
    } ist_state_t;

    // Packet probe handed from cell to cell
    typedef struct packed {
        logic               live;
        logic [IPID_W-1:0]  ipid;
        logic [STAMP_W-1:0] stamp;
        logic               hit;
        logic               free_found;
    } ist_probe_t;

    // Broadcast that opens a new sequence in the claimed cell
    typedef struct packed {
        logic               en;
        logic [IPID_W-1:0]  ipid;
        logic [STAMP_W-1:0] stamp;
    } ist_open_t;

endpackage
`default_nettype wire

// ----- rtl/core/ist_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPID sequence cell
// Holds one sequence slot, tests the passing probe against it and hands the
// probe on to the next cell through a register.
// ----------------------------------------------------------------------------
module ist_cell #(
    parameter int CELL_ID = 0,
    parameter int IDX_W   = 4
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [ist_pkg::GAP_W-1:0]     gap_limit,
    input  wire logic [ist_pkg::TIME_W-1:0]    time_limit,
    input  wire ist_pkg::ist_probe_t           probe_in,
    input  wire logic [IDX_W-1:0]              free_idx_in,
    output      ist_pkg::ist_probe_t           probe_out,
    output      logic [IDX_W-1:0]              free_idx_out,
    input  wire ist_pkg::ist_open_t            open_cmd,
    input  wire logic [IDX_W-1:0]              open_idx,
    output      logic                          match
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_ID);

    logic                           valid_reg;
    logic [ist_pkg::IPID_W-1:0]     last_ipid_reg;
    logic [ist_pkg::STAMP_W-1:0]    last_stamp_reg;
    logic                           live_reg;
    ist_pkg::ist_probe_t            probe_reg;
    ist_pkg::ist_probe_t            probe_next;
    logic [IDX_W-1:0]               free_idx_reg;
    logic [IDX_W-1:0]               free_idx_next;
    logic                           match_reg;

    logic [ist_pkg::IPID_W-1:0]     gap;
    logic [ist_pkg::STAMP_W-1:0]    dt;
    logic                           gap_ok;
    logic                           time_ok;
    logic                           accept;
    logic                           opening;

    always_comb
    begin
        gap     = (probe_in.ipid - last_ipid_reg) & ist_pkg::GAP_MOD_MASK;
        dt      = probe_in.stamp - last_stamp_reg;
        gap_ok  = gap < gap_limit;
        time_ok = (probe_in.stamp >= last_stamp_reg) && (dt < time_limit);
        accept  = probe_in.live && valid_reg && gap_ok && time_ok;
        opening = open_cmd.en && (open_idx == MY_IDX);

        probe_next     = probe_in;
        probe_next.hit = probe_in.hit | accept;
        free_idx_next  = free_idx_in;
        // The first free slot along the row claims the probe.
        if (probe_in.live && !valid_reg && !probe_in.free_found)
        begin
            probe_next.free_found = 1'b1;
            free_idx_next         = MY_IDX;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            live_reg  <= 1'b0;
        end
        else
        begin
            live_reg <= probe_in.live;
            if (opening)
            begin
                valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        probe_reg    <= probe_next;
        free_idx_reg <= free_idx_next;
        if (probe_in.live)
        begin
            match_reg <= accept;
        end
        if (accept)
        begin
            last_ipid_reg  <= probe_in.ipid;
            last_stamp_reg <= probe_in.stamp;
        end
        else if (opening)
        begin
            last_ipid_reg  <= open_cmd.ipid;
            last_stamp_reg <= open_cmd.stamp;
        end
    end

    always_comb
    begin
        probe_out      = probe_reg;
        probe_out.live = live_reg;
    end

    assign free_idx_out = free_idx_reg;
    assign match        = match_reg;

endmodule
`default_nettype wire

// ----- rtl/core/ipid_sequence_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// IPID sequence tracker
// Groups packets into IP identification sequences held in a row of cells.
// ----------------------------------------------------------------------------
// Usage: a packet transaction (ipid, stamp) is taken at a rising edge where
// start is high and busy is low. The packet then walks along a row of SLOTS
// sequence cells, one cell per cycle; each cell compares it with its own
// last IPID and timestamp and, when it accepts, takes the packet's values.
// The probe also notes the lowest free slot it passed. When it leaves the
// last cell the sequencer decides: if no sequence accepted and a slot is
// free, that slot is opened by a broadcast to the row; if none is free,
// table_full is raised. The result transaction (match_mask, opened,
// new_slot, table_full, slots_used) is shown for one cycle under done.
// done is registered from the probe leaving the last cell and busy falls
// with it; no new packet is taken before then. The receiver cannot stall;
// results are simply presented once. Configuration (gap_limit, time_limit)
// is written through cfg_wr_en, cfg_index and cfg_wdata; the user must
// write it only while the block is idle, which it does not enforce. Reset
// closes every slot, clears the open count and restores the limits to 64 and 300.
// ----------------------------------------------------------------------------
module ipid_sequence_tracker #(
    parameter int SLOTS = ist_pkg::SLOTS_DEFAULT
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire ist_pkg::ist_reg_idx_t         cfg_index,
    input  wire logic [ist_pkg::CFG_W-1:0]     cfg_wdata,
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic [ist_pkg::IPID_W-1:0]    ipid,
    input  wire logic [ist_pkg::STAMP_W-1:0]   stamp,
    output      logic                          done,
    output      logic [ist_pkg::MASK_W-1:0]    match_mask,
    output      logic                          opened,
    output      logic [ist_pkg::SLOT_W-1:0]    new_slot,
    output      logic                          table_full,
    output      logic [ist_pkg::USED_W-1:0]    slots_used
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    // Configuration registers
    logic [ist_pkg::GAP_W-1:0]  gap_limit_reg;
    logic [ist_pkg::TIME_W-1:0] time_limit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_limit_reg  <= ist_pkg::GAP_LIMIT_RESET;
            time_limit_reg <= ist_pkg::TIME_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ist_pkg::REG_GAP_LIMIT:  gap_limit_reg  <= ist_pkg::GAP_W'(cfg_wdata);
                ist_pkg::REG_TIME_LIMIT: time_limit_reg <= ist_pkg::TIME_W'(cfg_wdata);
                default:                 ;
            endcase
        end
    end

    // Sequencer: idle, or a probe is walking the row.
    ist_pkg::ist_state_t state_reg;
    ist_pkg::ist_state_t state_next;
    logic                take;

    ist_pkg::ist_probe_t probe   [SLOTS+1];
    logic [IDX_W-1:0]    free_idx[SLOTS+1];
    logic [SLOTS-1:0]    match_vec;
    ist_pkg::ist_open_t  open_cmd;
    ist_pkg::ist_probe_t tail;

    assign tail = probe[SLOTS];

    always_comb
    begin
        state_next = state_reg;
        take       = 1'b0;
        unique case (state_reg)
            ist_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    take       = 1'b1;
                    state_next = ist_pkg::ST_SWEEP;
                end
            end
            ist_pkg::ST_SWEEP:
            begin
                if (tail.live)
                begin
                    state_next = ist_pkg::ST_IDLE;
                end
            end
            default: state_next = ist_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ist_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg == ist_pkg::ST_SWEEP);

    // Probe entering the first cell
    always_comb
    begin
        probe[0].live       = take;
        probe[0].ipid       = ipid;
        probe[0].stamp      = stamp;
        probe[0].hit        = 1'b0;
        probe[0].free_found = 1'b0;
        free_idx[0]         = '0;
    end

    // A new sequence is opened when nothing accepted and a free slot was seen.
    always_comb
    begin
        open_cmd.en    = tail.live && !tail.hit && tail.free_found;
        open_cmd.ipid  = tail.ipid;
        open_cmd.stamp = tail.stamp;
    end

    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        ist_cell #(
            .CELL_ID (i),
            .IDX_W   (IDX_W)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .gap_limit    (gap_limit_reg),
            .time_limit   (time_limit_reg),
            .probe_in     (probe[i]),
            .free_idx_in  (free_idx[i]),
            .probe_out    (probe[i+1]),
            .free_idx_out (free_idx[i+1]),
            .open_cmd     (open_cmd),
            .open_idx     (free_idx[SLOTS]),
            .match        (match_vec[i])
        );
    end

    // Open count and result registers
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic                       done_reg;
    logic [ist_pkg::MASK_W-1:0] mask_reg;
    logic                       opened_reg;
    logic [ist_pkg::SLOT_W-1:0] new_slot_reg;
    logic                       full_reg;

    always_comb
    begin
        count_next = count_reg + CNT_W'(open_cmd.en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= tail.live;
        end
    end

    // Every cell has seen the probe by the time it leaves the row, so the
    // match bits are settled here. Slots from index sixteen up do not appear.
    always_ff @(posedge clk)
    begin
        if (tail.live)
        begin
            mask_reg     <= (tail.hit) ? ist_pkg::MASK_W'(match_vec) : '0;
            opened_reg   <= open_cmd.en;
            new_slot_reg <= open_cmd.en ? ist_pkg::SLOT_W'(free_idx[SLOTS]) : '0;
            full_reg     <= !tail.hit && !tail.free_found;
        end
    end

    assign done       = done_reg;
    assign match_mask = mask_reg;
    assign opened     = opened_reg;
    assign new_slot   = new_slot_reg;
    assign table_full = full_reg;
    assign slots_used = ist_pkg::USED_W'(count_reg);

endmodule
`default_nettype wire

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// IPID sequence tracker testbench
// Sends packet transactions (ipid, stamp) into the tracker and checks every
// result transaction against a behavioural copy of the sequence table kept in
// the bench. A short table of directed packets and register writes comes
// first. Random traffic follows under several gap and time limits, with the
// sender idling at different rates.
// ----------------------------------------------------------------------------
module tb_top;

    import ist_pkg::*;

    localparam int SLOTS       = SLOTS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTINGS_PER_PHASE = 5;
    localparam int PACKETS_PER_SETTING = 110;

    // One result transaction of the tracker, field for field.
    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              opened;
        logic [SLOT_W-1:0] slot;
        logic              full;
        logic [USED_W-1:0] used;
    } seq_outcome_t;

    typedef enum logic {
        ROW_PACKET,
        ROW_WRITE
    } row_kind_t;

    // One line of the directed table: either a packet or a register write.
    // Where fixed is set, the outcome is typed in by hand and replaces the
    // behavioural prediction for that packet.
    typedef struct {
        row_kind_t          kind;
        logic [IPID_W-1:0]  ipid;
        logic [STAMP_W-1:0] stamp;
        bit                 fixed;
        seq_outcome_t       outcome;
        ist_reg_idx_t       index;
        logic [CFG_W-1:0]   value;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_wr_en;
    ist_reg_idx_t        cfg_index;
    logic [CFG_W-1:0]    cfg_wdata;
    logic                start;
    logic                busy;
    logic [IPID_W-1:0]   ipid;
    logic [STAMP_W-1:0]  stamp;
    logic                done;
    logic [MASK_W-1:0]   match_mask;
    logic                opened;
    logic [SLOT_W-1:0]   new_slot;
    logic                table_full;
    logic [USED_W-1:0]   slots_used;

    // Bench copy of the sequence table and of the two limits.
    bit                  seq_open  [SLOTS];
    logic [IPID_W-1:0]   seq_ipid  [SLOTS];
    logic [STAMP_W-1:0]  seq_stamp [SLOTS];
    int                  open_total;
    logic [GAP_W-1:0]    gap_cap;
    logic [TIME_W-1:0]   time_cap;

    seq_outcome_t        awaited_outcomes[$];
    plan_row_t           directed_plan[$];
    int                  mismatch_count;
    int                  cycle_count;
    int                  idle_pct;

    ipid_sequence_tracker #(
        .SLOTS (SLOTS)
    ) DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .start      (start),
        .busy       (busy),
        .ipid       (ipid),
        .stamp      (stamp),
        .done       (done),
        .match_mask (match_mask),
        .opened     (opened),
        .new_slot   (new_slot),
        .table_full (table_full),
        .slots_used (slots_used)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // Works out the result transaction for one packet and moves the bench
    // table on. Every open sequence that accepts takes the packet's values;
    // if none accepts, the lowest free slot is opened, or the table is full.
    function automatic seq_outcome_t track_packet(input logic [IPID_W-1:0] pid,
                                                  input logic [STAMP_W-1:0] pst);
        seq_outcome_t      res;
        logic [IPID_W-1:0] gap;
        bit                hit;
        res = '0;
        hit = 1'b0;
        for (int s = 0; s < SLOTS; s++)
        begin
            gap = (pid - seq_ipid[s]) & GAP_MOD_MASK;
            if (seq_open[s] && gap < gap_cap && pst >= seq_stamp[s]
                && (pst - seq_stamp[s]) < time_cap)
            begin
                hit = 1'b1;
                if (s < MASK_W)
                begin
                    res.mask[s] = 1'b1;
                end
                seq_ipid[s]  = pid;
                seq_stamp[s] = pst;
            end
        end
        if (!hit)
        begin
            for (int s = 0; s < SLOTS; s++)
            begin
                if (!seq_open[s] && !res.opened)
                begin
                    res.opened   = 1'b1;
                    res.slot     = SLOT_W'(s);
                    seq_open[s]  = 1'b1;
                    seq_ipid[s]  = pid;
                    seq_stamp[s] = pst;
                end
            end
            if (res.opened)
            begin
                open_total++;
            end
            else
            begin
                res.full = 1'b1;
            end
        end
        res.used = USED_W'(open_total);
        return res;
    endfunction

    // An empty table row with every field set.
    function automatic plan_row_t blank_row();
        plan_row_t row;
        row.kind    = ROW_PACKET;
        row.ipid    = '0;
        row.stamp   = '0;
        row.fixed   = 1'b0;
        row.outcome = '0;
        row.index   = REG_GAP_LIMIT;
        row.value   = '0;
        return row;
    endfunction

    task automatic add_packet(input logic [IPID_W-1:0] pid, input logic [STAMP_W-1:0] pst);
        plan_row_t row;
        row       = blank_row();
        row.kind  = ROW_PACKET;
        row.ipid  = pid;
        row.stamp = pst;
        directed_plan.insert(directed_plan.size(), row);
    endtask

    task automatic add_checked(input logic [IPID_W-1:0] pid, input logic [STAMP_W-1:0] pst,
                               input logic [MASK_W-1:0] mask, input logic was_opened,
                               input logic [SLOT_W-1:0] slot, input logic full,
                               input logic [USED_W-1:0] used);
        plan_row_t row;
        row         = blank_row();
        row.kind    = ROW_PACKET;
        row.ipid    = pid;
        row.stamp   = pst;
        row.fixed   = 1'b1;
        row.outcome = '{mask: mask, opened: was_opened, slot: slot, full: full, used: used};
        directed_plan.insert(directed_plan.size(), row);
    endtask

    task automatic add_write(input ist_reg_idx_t idx, input logic [CFG_W-1:0] value);
        plan_row_t row;
        row       = blank_row();
        row.kind  = ROW_WRITE;
        row.index = idx;
        row.value = value;
        directed_plan.insert(directed_plan.size(), row);
    endtask

    // Holds one packet on the inputs until the tracker takes it. Each cycle
    // start is dropped with the current idle probability, so the gaps land
    // on any phase of the walk along the row, including the edge where busy
    // falls. The expectation is queued at the accepting edge.
    task automatic send_packet(input logic [IPID_W-1:0] pid, input logic [STAMP_W-1:0] pst,
                               input bit fixed, input seq_outcome_t typed_outcome);
        seq_outcome_t predicted;
        ipid  <= pid;
        stamp <= pst;
        forever
        begin
            start <= ($urandom_range(99) >= idle_pct);
            @(posedge clk);
            if (start && !busy)
            begin
                break;
            end
        end
        predicted = track_packet(pid, pst);
        awaited_outcomes.insert(awaited_outcomes.size(), fixed ? typed_outcome : predicted);
    endtask

    // Register writes only go in once every packet in flight has reported
    // back and the tracker is no longer busy.
    task automatic write_register(input ist_reg_idx_t idx, input logic [CFG_W-1:0] value);
        start <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (awaited_outcomes.size() != 0 || busy);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        if (idx == REG_GAP_LIMIT)
        begin
            gap_cap = value[GAP_W-1:0];
        end
        else
        begin
            time_cap = value[TIME_W-1:0];
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Result checker: every strobe must meet the oldest expectation.
    always @(posedge clk)
    begin
        seq_outcome_t want;
        if (rst_n && done)
        begin
            if (awaited_outcomes.size() == 0)
            begin
                $error("result transaction with nothing expected: match_mask %h", match_mask);
                mismatch_count++;
            end
            else
            begin
                want = awaited_outcomes.pop_front();
                if (match_mask !== want.mask)
                begin
                    $error("match_mask: expected %h, got %h", want.mask, match_mask);
                    mismatch_count++;
                end
                if (opened !== want.opened)
                begin
                    $error("opened: expected %b, got %b", want.opened, opened);
                    mismatch_count++;
                end
                if (new_slot !== want.slot)
                begin
                    $error("new_slot: expected %0d, got %0d", want.slot, new_slot);
                    mismatch_count++;
                end
                if (table_full !== want.full)
                begin
                    $error("table_full: expected %b, got %b", want.full, table_full);
                    mismatch_count++;
                end
                if (slots_used !== want.used)
                begin
                    $error("slots_used: expected %0d, got %0d", want.used, slots_used);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top: errors");
            $finish;
        end
    end

    initial
    begin
        int               s_pick;
        int               gspan;
        int               d;
        logic [TIME_W-1:0] tspan;
        logic [TIME_W-1:0] dt;
        logic [IPID_W-1:0] pid;
        logic [STAMP_W-1:0] pst;
        logic [GAP_W-1:0] gap_pick;
        logic [TIME_W-1:0] time_pick;
        plan_row_t        row;

        cycle_count    = 0;
        mismatch_count = 0;
        idle_pct       = 0;
        open_total     = 0;
        gap_cap        = GAP_LIMIT_RESET;
        time_cap       = TIME_LIMIT_RESET;
        for (int s = 0; s < SLOTS; s++)
        begin
            seq_open[s] = 1'b0;
        end

        rst_n     <= 1'b0;
        cfg_wr_en <= 1'b0;
        cfg_index <= REG_GAP_LIMIT;
        cfg_wdata <= '0;
        start     <= 1'b0;
        ipid      <= '0;
        stamp     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. The first rows run on the reset limits of 64 and
        // 300: a first packet, a gap and a time difference one short of each
        // limit, a gap exactly on the limit, and an earlier timestamp.
        add_checked(16'd0,   32'd0,   16'h0000, 1'b1, 4'd0, 1'b0, 5'd1);
        add_checked(16'd63,  32'd299, 16'h0001, 1'b0, 4'd0, 1'b0, 5'd1);
        add_checked(16'd127, 32'd299, 16'h0000, 1'b1, 4'd1, 1'b0, 5'd2);
        add_checked(16'd128, 32'd298, 16'h0000, 1'b1, 4'd2, 1'b0, 5'd3);
        // The IPID distance wraps at 15 bits: this one is gap zero to slot 2.
        add_packet(16'd32896, 32'd298);
        add_packet(16'hFFFF, 32'hFFFF_FFFF);
        // Widest time window, then a stamp that falls behind its sequence.
        add_write(REG_TIME_LIMIT, 32'hFFFF_FFFF);
        add_packet(16'd5, 32'd0);
        add_packet(16'd6, 32'hFFFF_FFFE);
        // A gap limit of 32768 or more lets every distance through.
        add_write(REG_GAP_LIMIT, 32'd32768);
        add_packet(16'h1234, 32'hFFFF_FFFF);
        add_write(REG_GAP_LIMIT, 32'd65535);
        add_packet(16'hA5A5, 32'hFFFF_FFFF);
        // A zero time limit shuts every sequence, so the repeat opens a slot.
        add_write(REG_TIME_LIMIT, 32'd0);
        add_packet(16'hA5A5, 32'hFFFF_FFFF);
        add_write(REG_TIME_LIMIT, 32'd1);
        add_packet(16'hA5A5, 32'hFFFF_FFFF);
        // With a zero gap limit every packet opens a slot until none is left.
        add_write(REG_GAP_LIMIT, 32'd0);
        for (int k = 0; k < SLOTS - 6; k++)
        begin
            add_packet(IPID_W'(k * 4099), STAMP_W'(k * 7));
        end
        add_checked(16'h0000, 32'd0,          16'h0000, 1'b0, 4'd0, 1'b1, 5'd16);
        add_checked(16'hFFFF, 32'hFFFF_FFFF, 16'h0000, 1'b0, 4'd0, 1'b1, 5'd16);

        foreach (directed_plan[i])
        begin
            row = directed_plan[i];
            if (row.kind == ROW_WRITE)
            begin
                write_register(row.index, row.value);
            end
            else
            begin
                send_packet(row.ipid, row.stamp, row.fixed, row.outcome);
            end
        end

        // Random traffic in three phases of sender idling, each through
        // several limit settings. Three packets in four, where the picked slot is
        // open, follow its sequence with a random step, mostly small, so many of
        // them join; the rest are full-range noise.
        for (int phase = 0; phase < 3; phase++)
        begin
            idle_pct = (phase == 0) ? 12 : (phase == 1) ? 46 : 0;
            for (int setting = 0; setting < SETTINGS_PER_PHASE; setting++)
            begin
                case ($urandom_range(9))
                    0:       gap_pick = 16'd1;
                    1:       gap_pick = 16'd32768;
                    2:       gap_pick = 16'hFFFF;
                    3:       gap_pick = 16'd64;
                    4:       gap_pick = ($urandom_range(19) == 0) ? 16'd0 : 16'd2;
                    5, 6:    gap_pick = GAP_W'($urandom_range(2, 256));
                    default: gap_pick = GAP_W'($urandom_range(1, 4096));
                endcase
                case ($urandom_range(9))
                    0:       time_pick = 32'd1;
                    1:       time_pick = 32'hFFFF_FFFF;
                    2:       time_pick = 32'd300;
                    3:       time_pick = ($urandom_range(9) == 0) ? 32'd0 : 32'd2;
                    default: time_pick = $urandom_range(1, 5000);
                endcase
                write_register(REG_GAP_LIMIT, CFG_W'(gap_pick));
                write_register(REG_TIME_LIMIT, CFG_W'(time_pick));

                for (int n = 0; n < PACKETS_PER_SETTING; n++)
                begin
                    s_pick = $urandom_range(SLOTS - 1);
                    if ($urandom_range(3) != 0 && seq_open[s_pick])
                    begin
                        gspan = (gap_cap == 0) ? 0 : (gap_cap > 32768) ? 32767 : gap_cap - 1;
                        tspan = (time_cap == 0) ? '0 : time_cap - 1;
                        case ($urandom_range(9))
                            0, 1, 2, 3, 4: d = $urandom_range(0, (gspan > 200) ? 200 : gspan);
                            5, 6:          d = $urandom_range(0, gspan);
                            7:             d = gspan + 1;
                            default:       d = $urandom;
                        endcase
                        case ($urandom_range(9))
                            0, 1, 2, 3, 4, 5: dt = $urandom_range(0, (tspan > 600) ? 600 : tspan);
                            6:                dt = $urandom_range(0, tspan);
                            7:                dt = time_cap;
                            default:          dt = -TIME_W'($urandom_range(1, 3));
                        endcase
                        pid = seq_ipid[s_pick] + IPID_W'(d);
                        pst = seq_stamp[s_pick] + dt;
                    end
                    else
                    begin
                        pid = IPID_W'($urandom);
                        pst = $urandom;
                    end
                    send_packet(pid, pst, 1'b0, '0);
                end
            end
        end

        start <= 1'b0;
        while (awaited_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SLOTS + 4) @(posedge clk);

        if (mismatch_count == 0 && awaited_outcomes.size() == 0)
        begin
            $display("tb_top: clean");
        end
        else
        begin
            $display("tb_top: errors");
        end
        $finish;
    end

endmodule
